[rtl/core/bpfl_pkg.sv]
// Package for the buffer pool free list unit.
// Holds the pool sizing constants, the operation and status codes and the register map.
// No dependencies.
package bpfl_pkg;

  localparam int MAX_BUFFERS = 64;
  localparam int IDX_W       = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int CNT_W       = $clog2(MAX_BUFFERS + 1);
  localparam int CFG_W       = 7;
  localparam int KIND_W      = 3;

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_W   = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_BUFFER_COUNT = '0;

  typedef enum logic [KIND_W-1:0] {
    OP_INIT     = 3'd0,
    OP_GET      = 3'd1,
    OP_COMPLETE = 3'd2,
    OP_RELEASE  = 3'd3,
    OP_RESET    = 3'd4
  } op_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_STATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

endpackage

[rtl/core/bpfl_if.sv]
// Request and response channel interfaces of the buffer pool free list unit.
// Depends on bpfl_pkg.
interface bpfl_req_if;
  import bpfl_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [IDX_W-1:0]    rel_index;

  modport source (output valid, output kind, output rel_index, input ready);
  modport sink   (input valid, input kind, input rel_index, output ready);
endinterface

interface bpfl_rsp_if;
  import bpfl_pkg::*;
  logic                valid;
  logic                ready;
  status_t             status;
  logic [IDX_W-1:0]    result_index;
  logic                in_progress;
  logic [CNT_W-1:0]    free_count;

  modport source (output valid, output status, output result_index, output in_progress,
                  output free_count, input ready);
  modport sink   (input valid, input status, input result_index, input in_progress,
                  input free_count, output ready);
endinterface

[rtl/core/bpfl_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bpfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/core/bpfl_ctrl.sv]
// Free list sequencer: decodes operations, pops and pushes the stack memory,
// keeps the free marks in a second memory, the current buffer and the response register.
// Depends on bpfl_pkg, bpfl_if and bpfl_ram.
module bpfl_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [bpfl_pkg::CFG_W-1:0] buffer_count,
  bpfl_req_if.sink                req,
  bpfl_rsp_if.source              rsp
);
  import bpfl_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WALK, S_FIN} state_t;

  state_t               state;
  logic [KIND_W-1:0]    op_kind;
  logic [IDX_W-1:0]     op_idx;
  logic [CNT_W-1:0]     depth;
  logic [CNT_W-1:0]     pool_size;
  logic [CNT_W-1:0]     walk_idx;
  logic                 cur_valid;
  logic [IDX_W-1:0]     cur_index;

  logic                 rsp_valid;
  status_t              rsp_status;
  logic [IDX_W-1:0]     rsp_index;
  logic                 rsp_busy;
  logic [CNT_W-1:0]     rsp_count;

  // stack memory
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [IDX_W-1:0]     mem_wdata;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic [IDX_W-1:0]     mem_rdata;

  // free mark memory
  logic                 mark_we;
  logic [IDX_W-1:0]     mark_waddr;
  logic [0:0]           mark_wdata;
  logic                 mark_re;
  logic [IDX_W-1:0]     mark_raddr;
  logic [0:0]           mark_rdata;

  // single-item decode results
  status_t              status_c;
  logic [IDX_W-1:0]     res_c;
  logic                 cv_c;
  logic [IDX_W-1:0]     ci_c;
  logic [CNT_W-1:0]     depth_c;
  logic                 push_c;
  logic                 pop_c;

  logic                 out_free;
  logic                 accept;
  logic                 walk_done;
  logic                 walk_push;
  logic                 stack_room;
  logic                 rsp_load;
  logic [CNT_W-1:0]     sat_count;

  assign out_free   = !rsp_valid || rsp.ready;
  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign stack_room = (depth < CNT_W'(MAX_BUFFERS));
  assign walk_done  = (walk_idx == pool_size);
  assign walk_push  = ((op_kind == OP_INIT) || !mark_rdata[0]) && stack_room;
  assign sat_count  = (32'(buffer_count) > 32'(MAX_BUFFERS)) ? CNT_W'(MAX_BUFFERS)
                                                             : CNT_W'(buffer_count);
  assign rsp_load   = out_free &&
                      (((state == S_EXEC) && (op_kind != OP_INIT) && (op_kind != OP_RESET)) ||
                       (state == S_FIN));

  // pop address is read speculatively on accept; no write is pending then
  assign mem_re    = accept;
  assign mem_raddr = IDX_W'(depth - CNT_W'(1));
  assign mem_waddr = depth[IDX_W-1:0];
  assign mem_wdata = (state == S_WALK) ? walk_idx[IDX_W-1:0] : op_idx;
  assign mem_we    = ((state == S_EXEC) && out_free && push_c) ||
                     ((state == S_WALK) && !walk_done && walk_push);

  // release mark is read on accept; the reset walk reads one index ahead of walk_idx
  assign mark_re    = accept || ((state == S_EXEC) && (op_kind == OP_RESET)) ||
                      (state == S_WALK);
  assign mark_raddr = (state == S_IDLE) ? req.rel_index :
                      (state == S_EXEC) ? '0 : IDX_W'(walk_idx + CNT_W'(1));
  assign mark_we    = mem_we || ((state == S_EXEC) && out_free && pop_c);
  assign mark_waddr = (state == S_WALK) ? walk_idx[IDX_W-1:0] : (pop_c ? mem_rdata : op_idx);
  assign mark_wdata = pop_c ? 1'b0 : 1'b1;

  bpfl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BUFFERS)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bpfl_ram #(
    .WIDTH (1),
    .DEPTH (MAX_BUFFERS)
  ) u_marks (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .re    (mark_re),
    .raddr (mark_raddr),
    .rdata (mark_rdata)
  );

  always_comb begin
    status_c = ST_OK;
    res_c    = '0;
    cv_c     = cur_valid;
    ci_c     = cur_index;
    depth_c  = depth;
    push_c   = 1'b0;
    pop_c    = 1'b0;
    unique case (op_kind)
      OP_INIT, OP_RESET: begin
        status_c = ST_OK;
      end
      OP_GET: begin
        if (cur_valid) begin
          status_c = ST_BAD_STATE;
        end else if (depth == '0) begin
          status_c = ST_NOT_FOUND;
        end else begin
          pop_c   = 1'b1;
          depth_c = depth - CNT_W'(1);
          res_c   = mem_rdata;
          ci_c    = mem_rdata;
          cv_c    = 1'b1;
        end
      end
      OP_COMPLETE: begin
        if (!cur_valid) begin
          status_c = ST_BAD_STATE;
        end else begin
          res_c = cur_index;
          cv_c  = 1'b0;
        end
      end
      OP_RELEASE: begin
        if (CNT_W'(op_idx) >= pool_size) begin
          status_c = ST_RANGE;
        end else if (mark_rdata[0]) begin
          status_c = ST_NOT_FOUND;
        end else begin
          if (cur_valid && (cur_index == op_idx)) begin
            cv_c = 1'b0;
          end
          if (stack_room) begin
            push_c  = 1'b1;
            depth_c = depth + CNT_W'(1);
          end
        end
      end
      default: begin
        status_c = ST_BAD_STATE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      pool_size <= '0;
      cur_valid <= 1'b0;
      cur_index <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_kind <= req.kind;
            op_idx  <= req.rel_index;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (op_kind == OP_INIT) begin
            // marks at or above the new pool size are never read, so only the walk writes them
            pool_size <= sat_count;
            depth     <= '0;
            cur_valid <= 1'b0;
            cur_index <= '0;
            walk_idx  <= '0;
            state     <= S_WALK;
          end else if (op_kind == OP_RESET) begin
            cur_valid <= 1'b0;
            walk_idx  <= '0;
            state     <= S_WALK;
          end else if (out_free) begin
            depth      <= depth_c;
            cur_valid  <= cv_c;
            cur_index  <= ci_c;
            rsp_status <= status_c;
            rsp_index  <= res_c;
            rsp_busy   <= cv_c;
            rsp_count  <= depth_c;
            state      <= S_IDLE;
          end
        end
        S_WALK: begin
          if (walk_done) begin
            state <= S_FIN;
          end else begin
            if (walk_push) begin
              depth <= depth + CNT_W'(1);
            end
            walk_idx <= walk_idx + CNT_W'(1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            rsp_status <= ST_OK;
            rsp_index  <= '0;
            rsp_busy   <= cur_valid;
            rsp_count  <= depth;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.result_index = rsp_index;
  assign rsp.in_progress  = rsp_busy;
  assign rsp.free_count   = rsp_count;

  a_depth_le_pool: assert property (@(posedge clk) disable iff (rst)
    depth <= pool_size)
    else $error("free list deeper than pool");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (walk_idx <= pool_size))
    else $error("walk index past pool size");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted item not executed");

  // a stalled result keeps its fields
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.ready) |=>
      (rsp_valid && $stable({rsp_status, rsp_index, rsp_busy, rsp_count})))
    else $error("stalled result changed");

endmodule

[rtl/core/buffer_pool_free_list_unit.sv]
// Top level of the buffer pool free list unit: APB configuration register and sequencer.
// Depends on bpfl_pkg, bpfl_if, bpfl_ctrl.
//
//   channel  dir  handshake       payload
//   req      in   valid/ready     kind, rel_index
//   rsp      out  valid/ready     status, result_index, in_progress, free_count
//   apb      in   psel/penable    paddr, pwdata (write), prdata (read), pready tied high
//
// Get, complete, release and unknown kinds: the result is registered once rsp is free and
// the next item is accepted only after that; the stack and mark reads issued at accept
// feed the decode.
// Init and reset: one index per cycle through the stack write port, then the result is
// registered once rsp is free; the reset walk reads each free mark one index ahead.
// rst is synchronous; free marks are not cleared, since init writes the mark of every
// pooled index and no mark at or above pool_size is ever read.
// A stalled rsp holds the finished result; the next item is accepted meanwhile. Init and
// reset walk at once; other kinds wait to commit until the response register frees.
module buffer_pool_free_list_unit (
  input  logic                              clk,
  input  logic                              rst,
  bpfl_req_if.sink                          req,
  bpfl_rsp_if.source                        rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bpfl_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bpfl_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bpfl_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import bpfl_pkg::*;

  logic [CFG_W-1:0]     buffer_count;
  logic [REG_IDX_W-1:0] reg_sel;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_count <= '0;
    end else if (cfg_wr && (reg_sel == REG_BUFFER_COUNT)) begin
      buffer_count <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BUFFER_COUNT: prdata = APB_DATA_W'(buffer_count);
      default:          prdata = '0;
    endcase
  end

  bpfl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .buffer_count (buffer_count),
    .req          (req),
    .rsp          (rsp)
  );

endmodule

[sim/bpfl_pool_checker.sv]
`timescale 1ns / 1ps
// Reply checker for the buffer pool free list unit: tracks the APB count register and the
// request channel, predicts every reply and compares it with the response channel.
// Depends on bpfl_pkg and bpfl_if.
module bpfl_pool_checker (
  input  logic                            clk,
  input  logic                            rst,
  bpfl_req_if                             req,
  bpfl_rsp_if                             rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [bpfl_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bpfl_pkg::APB_DATA_W-1:0] pwdata,
  output int                              fail_count,
  output int                              checked,
  output int                              leftover
);
  import bpfl_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] index;
    logic             busy;
    logic [CNT_W-1:0] free_left;
  } pool_reply_t;

  // shadow of the allocator
  logic [CFG_W-1:0]       count_reg;
  logic [IDX_W-1:0]       free_ids [MAX_BUFFERS];
  logic [CNT_W-1:0]       free_depth;
  logic [MAX_BUFFERS-1:0] free_mark;
  logic [CNT_W-1:0]       pool_len;
  logic                   held_valid;
  logic [IDX_W-1:0]       held_id;

  pool_reply_t replies_due[$];
  pool_reply_t want;

  function automatic void push_free(input logic [IDX_W-1:0] id);
    if (free_depth < CNT_W'(MAX_BUFFERS)) begin
      free_ids[free_depth[IDX_W-1:0]] = id;
      free_depth = free_depth + CNT_W'(1);
      free_mark[id] = 1'b1;
    end
  endfunction

  function automatic pool_reply_t run_pool_op(input logic [KIND_W-1:0] kind,
                                              input logic [IDX_W-1:0] id);
    pool_reply_t r;
    r.status = ST_OK;
    r.index  = '0;
    case (kind)
      OP_INIT: begin
        pool_len   = (count_reg > CFG_W'(MAX_BUFFERS)) ? CNT_W'(MAX_BUFFERS) : count_reg;
        free_depth = '0;
        free_mark  = '0;
        held_valid = 1'b0;
        held_id    = '0;
        for (int i = 0; i < int'(pool_len); i++) push_free(IDX_W'(i));
      end
      OP_GET: begin
        if (held_valid) begin
          r.status = ST_BAD_STATE;
        end else if (free_depth == '0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          free_depth = free_depth - CNT_W'(1);
          r.index = free_ids[free_depth[IDX_W-1:0]];
          free_mark[r.index] = 1'b0;
          held_id    = r.index;
          held_valid = 1'b1;
        end
      end
      OP_COMPLETE: begin
        if (!held_valid) begin
          r.status = ST_BAD_STATE;
        end else begin
          r.index    = held_id;
          held_valid = 1'b0;
        end
      end
      OP_RELEASE: begin
        if (CNT_W'(id) >= pool_len) begin
          r.status = ST_RANGE;
        end else if (free_mark[id]) begin
          r.status = ST_NOT_FOUND;
        end else begin
          if (held_valid && held_id == id) held_valid = 1'b0;
          push_free(id);
        end
      end
      OP_RESET: begin
        held_valid = 1'b0;
        // held buffers go back lowest index first
        for (int i = 0; i < int'(pool_len); i++) begin
          if (!free_mark[i]) push_free(IDX_W'(i));
        end
      end
      default: r.status = ST_BAD_STATE;
    endcase
    r.busy      = held_valid;
    r.free_left = free_depth;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: reply %0d %s mismatch: expected %0d, got %0d",
               $time, checked, what, exp_val, got_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      count_reg  = '0;
      free_depth = '0;
      free_mark  = '0;
      pool_len   = '0;
      held_valid = 1'b0;
      held_id    = '0;
      for (int i = 0; i < MAX_BUFFERS; i++) free_ids[i] = '0;
      replies_due.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1:2] == REG_BUFFER_COUNT)
        count_reg = pwdata[CFG_W-1:0];
      if (rsp.valid && rsp.ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected reply: expected none, got status %0d index %0d",
                   $time, rsp.status, rsp.result_index);
          fail_count++;
        end else begin
          want = replies_due[0];
          replies_due.delete(0);
          check_field("status", 32'(want.status), 32'(rsp.status));
          check_field("result_index", 32'(want.index), 32'(rsp.result_index));
          check_field("in_progress", 32'(want.busy), 32'(rsp.in_progress));
          check_field("free_count", 32'(want.free_left), 32'(rsp.free_count));
          checked++;
        end
      end
      if (req.valid && req.ready)
        replies_due.push_back(run_pool_op(req.kind, req.rel_index));
    end
    leftover = replies_due.size();
  end

endmodule

[sim/tb_buffer_pool_free_list_unit.sv]
`timescale 1ns / 1ps
// Testbench top for the buffer pool free list unit: clock, reset, APB count writes,
// request stimulus, response flow control, watchdog and verdict.
// Depends on bpfl_pkg, bpfl_if, bpfl_pool_checker and the unit itself.
module tb_buffer_pool_free_list_unit;
  import bpfl_pkg::*;

  localparam logic [KIND_W-1:0] FIRST_SPARE_KIND = 3'd5;
  localparam logic [KIND_W-1:0] LAST_SPARE_KIND  = 3'd7;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 190;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 4000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;

  int  sent = 0;
  int  replies = 0;
  int  kind_sent[8];
  int  quiet_cycles = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  bit  calm = 1'b0;
  int  fail_count, checked, leftover;

  bpfl_req_if req_ch ();
  bpfl_rsp_if rsp_ch ();

  buffer_pool_free_list_unit dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bpfl_pool_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .checked    (checked),
    .leftover   (leftover)
  );

  always #1 clk = ~clk;

  // response side: random back-pressure, one long hold-off, none while calm
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      replies      <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) replies <= replies + 1;
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
        rsp_ch.ready <= 1'b0;
        hold_left    <= HOLD_CYCLES;
        hold_done    <= 1'b1;
      end else begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic issue_op(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] id);
    while (!calm && $urandom_range(99) < 34) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= kind;
    req_ch.rel_index <= id;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
    kind_sent[kind]++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (replies != sent) @(posedge clk);
  endtask

  task automatic write_count(input int value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_BUFFER_COUNT, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int phase_counts[PHASES];
    int cnt, pool, pick;
    logic [IDX_W-1:0] id;

    phase_counts = '{64, 127, 1, 7, 0, 0, 65, 0};
    req_ch.valid     <= 1'b0;
    req_ch.kind      <= OP_INIT;
    req_ch.rel_index <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty pool
    write_count(0);
    issue_op(OP_INIT, '0);
    issue_op(OP_GET, '0);
    issue_op(OP_RELEASE, '0);
    issue_op(OP_RESET, '0);
    issue_op(OP_COMPLETE, '0);

    // small pool: range, double free, busy, cancel on release
    write_count(5);
    issue_op(OP_INIT, '0);
    issue_op(OP_RELEASE, 6'd5);
    issue_op(OP_RELEASE, 6'd63);
    issue_op(OP_RELEASE, 6'd2);
    issue_op(OP_GET, '0);
    issue_op(OP_GET, '0);
    issue_op(OP_COMPLETE, '0);
    issue_op(OP_COMPLETE, '0);
    issue_op(OP_RELEASE, 6'd4);
    issue_op(OP_GET, '0);
    issue_op(OP_RELEASE, 6'd4);
    issue_op(OP_GET, '0);
    issue_op(OP_RESET, '0);
    for (int k = FIRST_SPARE_KIND; k <= LAST_SPARE_KIND; k++) issue_op(KIND_W'(k), 6'd63);

    // count above the pool limit saturates
    write_count(127);
    issue_op(OP_INIT, '0);
    issue_op(OP_GET, '0);
    issue_op(OP_COMPLETE, '0);
    issue_op(OP_GET, '0);
    issue_op(OP_RESET, '0);
    issue_op(OP_RELEASE, 6'd63);

    for (int ph = 0; ph < PHASES; ph++) begin
      cnt = phase_counts[ph];
      if (ph == 5 || ph == 7) cnt = $urandom_range(127);
      pool = (cnt > MAX_BUFFERS) ? MAX_BUFFERS : cnt;
      write_count(cnt);
      calm = (ph == 2);
      issue_op(OP_INIT, IDX_W'($urandom_range(63)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 40) hold_req = 1'b1;
        if (ph == 3 && n == 95) drain();
        pick = $urandom_range(99);
        id   = IDX_W'($urandom_range(63));
        if (pick < 30) begin
          issue_op(OP_GET, id);
        end else if (pick < 52) begin
          issue_op(OP_COMPLETE, id);
        end else if (pick < 82) begin
          // mostly indices inside the pool so releases hit held buffers
          if (pool > 0) id = IDX_W'($urandom_range(pool - 1));
          issue_op(OP_RELEASE, id);
        end else if (pick < 88) begin
          issue_op(OP_RELEASE, id);
        end else if (pick < 94) begin
          issue_op(OP_RESET, id);
        end else if (pick < 96) begin
          issue_op(OP_INIT, id);
        end else begin
          issue_op(KIND_W'($urandom_range(LAST_SPARE_KIND, FIRST_SPARE_KIND)), id);
        end
      end
      calm = 1'b0;
    end

    drain();
    repeat (80) @(posedge clk);
    $display("Sent %0d items over %0d pool sizes: init %0d, get %0d, complete %0d, release %0d,",
             sent, PHASES + 3, kind_sent[OP_INIT], kind_sent[OP_GET],
             kind_sent[OP_COMPLETE], kind_sent[OP_RELEASE]);
    $display("reset %0d, spare kinds %0d; %0d replies compared, with a %0d-cycle reply stall",
             kind_sent[OP_RESET], kind_sent[5] + kind_sent[6] + kind_sent[7], checked,
             HOLD_CYCLES);
    if (fail_count == 0 && leftover == 0) begin
      $display("RESULT: OK");
    end else begin
      if (leftover != 0) $display("%0d expected replies never arrived", leftover);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bpfl_pkg.sv
rtl/core/bpfl_if.sv
rtl/core/bpfl_ram.sv
rtl/core/bpfl_ctrl.sv
rtl/core/buffer_pool_free_list_unit.sv
sim/bpfl_pool_checker.sv
sim/tb_buffer_pool_free_list_unit.sv
